/* design/tab_pkg.sv */
`default_nettype none

package tab_pkg;

    // bus access kinds
    typedef enum logic [1:0] {
        MODE_IO_RD  = 2'd0,
        MODE_IO_WR  = 2'd1,
        MODE_MEM_RD = 2'd2,
        MODE_MEM_WR = 2'd3
    } mode_t;

    // crtc register file
    localparam int CRTC_COUNT = 18;
    localparam logic [4:0] CRTC_LIMIT = 5'd18;

    localparam logic [4:0] REG_HTOTAL       = 5'd0;
    localparam logic [4:0] REG_HSYNC_WIDTH  = 5'd3;
    localparam logic [4:0] REG_VTOTAL       = 5'd4;
    localparam logic [4:0] REG_VTOTAL_ADJ   = 5'd5;
    localparam logic [4:0] REG_VDISPLAYED   = 5'd6;
    localparam logic [4:0] REG_VSYNC_POS    = 5'd7;
    localparam logic [4:0] REG_MAX_SCAN     = 5'd9;
    localparam logic [4:0] REG_CURSOR_START = 5'd10;
    localparam logic [4:0] REG_CURSOR_END   = 5'd11;
    localparam logic [4:0] REG_START_HI     = 5'd12;
    localparam logic [4:0] REG_START_LO     = 5'd13;
    localparam logic [4:0] REG_CURSOR_HI    = 5'd14;
    localparam logic [4:0] REG_CURSOR_LO    = 5'd15;

    localparam logic [7:0] CRTC_INIT [CRTC_COUNT] = '{
        8'd99, 8'd80, 8'd82, 8'd12, 8'd31, 8'd1, 8'd25, 8'd27, 8'd0,
        8'd13, 8'd11, 8'd12, 8'd0, 8'd0, 8'd0, 8'd92, 8'd0, 8'd0
    };

    // io ports, low four address bits
    localparam logic [3:0] PORT_MODE   = 4'h8;
    localparam logic [3:0] PORT_STATUS = 4'ha;

    // memory window 0xb0000..0xb7fff
    localparam logic [4:0] WIN_TAG = 5'b10110;

    localparam logic [7:0]  STATUS_BASE = 8'hf0;
    localparam logic [15:0] BLANK_CELL  = 16'h0720;
    localparam logic [7:0]  MODE_RESET  = 8'h28;
    localparam int MC_HIRES_BIT = 3;
    localparam int MC_BLINK_BIT = 5;

    // decoded access held in the input stage
    typedef struct packed {
        mode_t       mode;
        logic [3:0]  port;
        logic        win_hit;
        logic        hi_byte;
        logic [13:0] cell_addr;
        logic [7:0]  data;
        logic [5:0]  timer;
    } access_t;

    typedef struct packed {
        logic        claimed;
        logic [7:0]  read_data;
        logic        dirty_first_valid;
        logic [10:0] dirty_first_cell;
        logic        dirty_second_valid;
        logic [10:0] dirty_second_cell;
        logic        full_redraw_pulse;
        logic        attr_high_pulse;
    } result_t;

    // bits kept by a crtc write
    function automatic logic [7:0] crtc_mask(input logic [4:0] idx);
        logic [7:0] m;
        begin
            unique case (idx)
                REG_HSYNC_WIDTH: m = 8'h0f;
                REG_VTOTAL, REG_VDISPLAYED, REG_VSYNC_POS, REG_CURSOR_START: m = 8'h7f;
                REG_VTOTAL_ADJ, REG_MAX_SCAN, REG_CURSOR_END: m = 8'h1f;
                REG_START_HI, REG_CURSOR_HI: m = 8'h3f;
                default: m = 8'hff;
            endcase
            return m;
        end
    endfunction

    // cell position relative to the screen start, wraps at 16k cells
    function automatic logic [13:0] cell_offset(input logic [13:0] addr,
                                                input logic [13:0] start);
        return addr - start;
    endfunction

endpackage

`default_nettype wire

/* design/tab_if.sv */
`default_nettype none

// bus access channel
interface tab_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [19:0] address;
    logic [7:0]  write_data;
    logic [5:0]  timer_bits;

    modport source (output valid, mode, address, write_data, timer_bits, input ready);
    modport sink   (input valid, mode, address, write_data, timer_bits, output ready);
endinterface

// access result channel
interface tab_rsp_if;
    logic        valid;
    logic        ready;
    logic        claimed;
    logic [7:0]  read_data;
    logic        dirty_first_valid;
    logic [10:0] dirty_first_cell;
    logic        dirty_second_valid;
    logic [10:0] dirty_second_cell;
    logic        full_redraw_pulse;
    logic        attr_high_pulse;

    modport source (output valid, claimed, read_data, dirty_first_valid, dirty_first_cell,
                    dirty_second_valid, dirty_second_cell, full_redraw_pulse,
                    attr_high_pulse, input ready);
    modport sink   (input valid, claimed, read_data, dirty_first_valid, dirty_first_cell,
                    dirty_second_valid, dirty_second_cell, full_redraw_pulse,
                    attr_high_pulse, output ready);
endinterface

`default_nettype wire

/* design/tab_cell_ram.sv */
`default_nettype none

module tab_cell_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [15:0]        rd_data
);

    logic [15:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/tab_exec.sv */
`default_nettype none

module tab_exec #(
    parameter int AW            = 14,
    parameter int VISIBLE_CELLS = 2000
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             s1_valid,
    input  wire tab_pkg::access_t s1_acc,
    input  wire logic [AW-1:0]    s1_idx,
    input  wire logic [15:0]      rd_word,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_idx,
    output logic [15:0]           wr_word,
    output logic                  res_valid,
    output tab_pkg::result_t      res
);

    localparam logic [13:0] VIS_LIMIT = 14'(VISIBLE_CELLS);

    // stage two registers
    logic             s2_valid_reg;
    tab_pkg::access_t s2_acc_reg;
    logic [AW-1:0]    s2_idx_reg;

    // last word written, for a read issued at the same edge
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_idx_reg;
    logic [15:0]      fwd_word_reg;

    // architectural state
    logic [7:0]       crtc_file_reg [tab_pkg::CRTC_COUNT];
    logic [4:0]       crtc_ptr_reg;
    logic [7:0]       mode_ctl_reg;

    logic             res_valid_reg;
    tab_pkg::result_t res_reg;

    // combinational results
    tab_pkg::result_t res_next;
    logic             crtc_we;
    logic [7:0]       crtc_val;
    logic             ptr_we;
    logic             mode_we;
    logic             mem_we;
    logic [15:0]      word;
    logic [15:0]      merged_word;
    logic [7:0]       cur_val;
    logic             ptr_ok;
    logic [7:0]       hi12, lo13, hi14, lo15;
    logic [13:0]      start_cur, start_new, cursor_cur, cursor_new;
    logic [13:0]      slot1_addr, slot2_addr;
    logic [13:0]      vis1, vis2;
    logic             want1, want2;
    logic [7:0]       mode_diff;

    // crtc addressing and the new start and cursor values
    always_comb
    begin
        ptr_ok     = crtc_ptr_reg < tab_pkg::CRTC_LIMIT;
        cur_val    = ptr_ok ? crtc_file_reg[crtc_ptr_reg] : 8'h00;
        crtc_val   = s2_acc_reg.data & tab_pkg::crtc_mask(crtc_ptr_reg);
        hi12 = (crtc_ptr_reg == tab_pkg::REG_START_HI)  ? crtc_val : crtc_file_reg[12];
        lo13 = (crtc_ptr_reg == tab_pkg::REG_START_LO)  ? crtc_val : crtc_file_reg[13];
        hi14 = (crtc_ptr_reg == tab_pkg::REG_CURSOR_HI) ? crtc_val : crtc_file_reg[14];
        lo15 = (crtc_ptr_reg == tab_pkg::REG_CURSOR_LO) ? crtc_val : crtc_file_reg[15];
        start_cur  = {crtc_file_reg[12][5:0], crtc_file_reg[13]};
        cursor_cur = {crtc_file_reg[14][5:0], crtc_file_reg[15]};
        start_new  = {hi12[5:0], lo13};
        cursor_new = {hi14[5:0], lo15};
    end

    // cell word, forwarding the write made at the edge that issued its read
    always_comb
    begin
        word = (fwd_valid_reg && fwd_idx_reg == s2_idx_reg) ? fwd_word_reg : rd_word;
        merged_word = s2_acc_reg.hi_byte ? {s2_acc_reg.data, word[7:0]}
                                         : {word[15:8], s2_acc_reg.data};
        mode_diff = mode_ctl_reg ^ s2_acc_reg.data;
    end

    // access decode and events
    always_comb
    begin
        res_next   = '0;
        crtc_we    = 1'b0;
        ptr_we     = 1'b0;
        mode_we    = 1'b0;
        mem_we     = 1'b0;
        want1      = 1'b0;
        want2      = 1'b0;
        slot1_addr = s2_acc_reg.cell_addr;
        slot2_addr = cursor_new;
        unique case (s2_acc_reg.mode)
            tab_pkg::MODE_IO_RD:
            begin
                if (!s2_acc_reg.port[3] && s2_acc_reg.port[0])
                begin
                    res_next.claimed   = 1'b1;
                    res_next.read_data = cur_val;
                end
                else if (s2_acc_reg.port == tab_pkg::PORT_STATUS)
                begin
                    res_next.claimed   = 1'b1;
                    res_next.read_data = tab_pkg::STATUS_BASE
                                       | {4'h0, s2_acc_reg.timer[3], 3'b000}
                                       | {7'h00, s2_acc_reg.timer[5]};
                end
            end
            tab_pkg::MODE_IO_WR:
            begin
                res_next.claimed = 1'b1;
                if (!s2_acc_reg.port[3])
                begin
                    if (!s2_acc_reg.port[0])
                    begin
                        ptr_we = 1'b1;
                    end
                    else if (ptr_ok && cur_val != crtc_val)
                    begin
                        crtc_we = 1'b1;
                        unique case (crtc_ptr_reg)
                            tab_pkg::REG_MAX_SCAN:
                            begin
                                res_next.full_redraw_pulse = 1'b1;
                            end
                            tab_pkg::REG_CURSOR_START, tab_pkg::REG_CURSOR_END:
                            begin
                                want2 = 1'b1;
                            end
                            tab_pkg::REG_START_HI, tab_pkg::REG_START_LO:
                            begin
                                res_next.full_redraw_pulse = (start_new != start_cur);
                            end
                            tab_pkg::REG_CURSOR_HI, tab_pkg::REG_CURSOR_LO:
                            begin
                                slot1_addr = cursor_cur;
                                want1      = 1'b1;
                                want2      = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else if (s2_acc_reg.port == tab_pkg::PORT_MODE)
                begin
                    mode_we = 1'b1;
                    if (mode_diff[tab_pkg::MC_HIRES_BIT])
                    begin
                        res_next.full_redraw_pulse = 1'b1;
                    end
                    else if (mode_diff[tab_pkg::MC_BLINK_BIT])
                    begin
                        res_next.attr_high_pulse = 1'b1;
                    end
                end
            end
            tab_pkg::MODE_MEM_RD:
            begin
                if (s2_acc_reg.win_hit)
                begin
                    res_next.claimed   = 1'b1;
                    res_next.read_data = s2_acc_reg.hi_byte ? word[15:8] : word[7:0];
                end
            end
            tab_pkg::MODE_MEM_WR:
            begin
                if (s2_acc_reg.win_hit)
                begin
                    res_next.claimed = 1'b1;
                    if (merged_word != word)
                    begin
                        mem_we = 1'b1;
                        want1  = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // visibility against the current start address
        vis1 = tab_pkg::cell_offset(slot1_addr, start_cur);
        vis2 = tab_pkg::cell_offset(slot2_addr, start_cur);
        if (want1 && vis1 < VIS_LIMIT)
        begin
            res_next.dirty_first_valid = 1'b1;
            res_next.dirty_first_cell  = vis1[10:0];
        end
        if (want2 && vis2 < VIS_LIMIT)
        begin
            res_next.dirty_second_valid = 1'b1;
            res_next.dirty_second_cell  = vis2[10:0];
        end
    end

    assign wr_en     = en && s2_valid_reg && mem_we;
    assign wr_idx    = s2_idx_reg;
    assign wr_word   = merged_word;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            crtc_ptr_reg  <= 5'd0;
            mode_ctl_reg  <= tab_pkg::MODE_RESET;
            for (int i = 0; i < tab_pkg::CRTC_COUNT; i++)
            begin
                crtc_file_reg[i] <= tab_pkg::CRTC_INIT[i];
            end
        end
        else if (en)
        begin
            s2_valid_reg  <= s1_valid;
            fwd_valid_reg <= s2_valid_reg && mem_we;
            res_valid_reg <= s2_valid_reg;
            if (s2_valid_reg && ptr_we)
            begin
                crtc_ptr_reg <= s2_acc_reg.data[4:0];
            end
            if (s2_valid_reg && mode_we)
            begin
                mode_ctl_reg <= s2_acc_reg.data;
            end
            if (s2_valid_reg && crtc_we)
            begin
                crtc_file_reg[crtc_ptr_reg] <= crtc_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_acc_reg   <= s1_acc;
            s2_idx_reg   <= s1_idx;
            fwd_idx_reg  <= s2_idx_reg;
            fwd_word_reg <= merged_word;
            res_reg      <= res_next;
        end
    end

endmodule

`default_nettype wire

/* design/text_adapter_bus_interface.sv */
// Bus interface of a monochrome text adapter with a 6845-style CRTC.
// req carries one bus access (io or memory, read or write) per transfer;
// rsp returns one result per access: read data, claimed flag, up to two
// visible dirty cells relative to the start address, and redraw pulses.
// Pipeline: the input stage issues the cell memory read; the second stage
// decodes, updates state, writes the cell memory and loads the result
// register.
// Throughput: one access per cycle unless rsp stalls; an access to the cell
// just written by the previous access is served from a forwarding register.
// Reset: CRTC registers, index pointer and mode control take their power-on
// values at once; then a clearing pass writes the cell memory one word per
// cycle over all CELL_WORDS words, blank 0x0720 cells on the visible screen
// and zero elsewhere. req.ready stays low during that pass.
// Stall: while a result waits on rsp.ready the whole pipeline holds; a new
// access is still taken whenever the result register is free or is being
// taken in the same cycle.
`default_nettype none

module text_adapter_bus_interface #(
    parameter int CELL_WORDS    = 16384,
    parameter int VISIBLE_CELLS = 2000
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tab_req_if.sink     req,
    tab_rsp_if.source   rsp
);

    localparam int AW        = $clog2(CELL_WORDS);
    localparam int MOD_STEPS = 16383 / CELL_WORDS;
    localparam logic [AW:0] VIS_LIMIT = (AW+1)'(VISIBLE_CELLS);
    localparam logic [AW-1:0] LAST_IDX = AW'(CELL_WORDS - 1);

    logic             en;
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_idx_reg;
    logic             s1_valid_reg;
    tab_pkg::access_t s1_acc_reg;
    logic [AW-1:0]    s1_idx_reg;
    tab_pkg::access_t acc_next;
    logic [AW-1:0]    idx_next;
    logic [14:0]      rem_wide;
    logic [13:0]      raw_idx;
    logic             ex_wr_en;
    logic [AW-1:0]    ex_wr_idx;
    logic [15:0]      ex_wr_word;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [15:0]      ram_wdata;
    logic [15:0]      rd_word;
    logic             res_valid;
    tab_pkg::result_t res;

    // pipeline advances when the result register is free or drained
    assign en        = !res_valid || rsp.ready;
    assign req.ready = en && !clr_busy_reg;

    // decode of the incoming access, word index reduced to the memory depth
    always_comb
    begin
        raw_idx  = req.address[14:1];
        rem_wide = {1'b0, raw_idx};
        for (int k = 1; k <= MOD_STEPS; k++)
        begin
            if ({1'b0, raw_idx} >= 15'(k * CELL_WORDS))
            begin
                rem_wide = {1'b0, raw_idx} - 15'(k * CELL_WORDS);
            end
        end
        idx_next           = rem_wide[AW-1:0];
        acc_next.mode      = tab_pkg::mode_t'(req.mode);
        acc_next.port      = req.address[3:0];
        acc_next.win_hit   = req.address[19:15] == tab_pkg::WIN_TAG;
        acc_next.hi_byte   = req.address[0];
        acc_next.cell_addr = raw_idx;
        acc_next.data      = req.write_data;
        acc_next.timer     = req.timer_bits;
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req.valid && req.ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_acc_reg <= acc_next;
            s1_idx_reg <= idx_next;
        end
    end

    // memory write port is shared by the clearing pass and stage two
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = ({1'b0, clr_idx_reg} < VIS_LIMIT) ? tab_pkg::BLANK_CELL : 16'h0000;
        end
        else
        begin
            ram_we    = ex_wr_en;
            ram_waddr = ex_wr_idx;
            ram_wdata = ex_wr_word;
        end
    end

    tab_cell_ram #(
        .DEPTH (CELL_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (en),
        .rd_addr (s1_idx_reg),
        .rd_data (rd_word)
    );

    tab_exec #(
        .AW            (AW),
        .VISIBLE_CELLS (VISIBLE_CELLS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s1_valid  (s1_valid_reg),
        .s1_acc    (s1_acc_reg),
        .s1_idx    (s1_idx_reg),
        .rd_word   (rd_word),
        .wr_en     (ex_wr_en),
        .wr_idx    (ex_wr_idx),
        .wr_word   (ex_wr_word),
        .res_valid (res_valid),
        .res       (res)
    );

    // result channel
    assign rsp.valid              = res_valid;
    assign rsp.claimed            = res.claimed;
    assign rsp.read_data          = res.read_data;
    assign rsp.dirty_first_valid  = res.dirty_first_valid;
    assign rsp.dirty_first_cell   = res.dirty_first_cell;
    assign rsp.dirty_second_valid = res.dirty_second_valid;
    assign rsp.dirty_second_cell  = res.dirty_second_cell;
    assign rsp.full_redraw_pulse  = res.full_redraw_pulse;
    assign rsp.attr_high_pulse    = res.attr_high_pulse;

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

localparam int SCREEN_CELLS = 2000;
localparam int CELL_DEPTH   = 16384;

// tracks adapter state and the results each bus transfer should produce
class access_scoreboard;
    logic [15:0]       cells [CELL_DEPTH];
    logic [7:0]        crtc [tab_pkg::CRTC_COUNT];
    logic [4:0]        index_reg;
    logic [7:0]        mode_ctl;
    tab_pkg::result_t  expected_q [$];
    int                failures;

    function new();
        for (int i = 0; i < CELL_DEPTH; i++)
            cells[i] = (i < SCREEN_CELLS) ? tab_pkg::BLANK_CELL : 16'h0000;
        for (int i = 0; i < tab_pkg::CRTC_COUNT; i++)
            crtc[i] = tab_pkg::CRTC_INIT[i];
        index_reg = 5'd0;
        mode_ctl  = tab_pkg::MODE_RESET;
        failures  = 0;
    endfunction

    function logic [13:0] screen_start();
        return {crtc[tab_pkg::REG_START_HI][5:0], crtc[tab_pkg::REG_START_LO]};
    endfunction

    function logic [13:0] cursor_pos();
        return {crtc[tab_pkg::REG_CURSOR_HI][5:0], crtc[tab_pkg::REG_CURSOR_LO]};
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // report a cell in one slot when it falls on the visible screen
    function void mark_cell(inout tab_pkg::result_t r, input bit second_slot,
                            input logic [13:0] addr);
        logic [13:0] rel;
        rel = addr - screen_start();
        if (rel < SCREEN_CELLS) begin
            if (second_slot) begin
                r.dirty_second_valid = 1'b1;
                r.dirty_second_cell  = rel[10:0];
            end
            else begin
                r.dirty_first_valid = 1'b1;
                r.dirty_first_cell  = rel[10:0];
            end
        end
    endfunction

    // masked register write with its redraw events
    function void write_crtc(input logic [7:0] d, inout tab_pkg::result_t r);
        logic [13:0] prev_start;
        logic [13:0] prev_cursor;
        logic [7:0]  kept;
        if (index_reg >= tab_pkg::CRTC_LIMIT)
            return;
        prev_start  = screen_start();
        prev_cursor = cursor_pos();
        case (index_reg)
            tab_pkg::REG_HSYNC_WIDTH: kept = d & 8'h0f;
            tab_pkg::REG_VTOTAL, tab_pkg::REG_VDISPLAYED, tab_pkg::REG_VSYNC_POS,
            tab_pkg::REG_CURSOR_START: kept = d & 8'h7f;
            tab_pkg::REG_VTOTAL_ADJ, tab_pkg::REG_MAX_SCAN,
            tab_pkg::REG_CURSOR_END: kept = d & 8'h1f;
            tab_pkg::REG_START_HI, tab_pkg::REG_CURSOR_HI: kept = d & 8'h3f;
            default: kept = d;
        endcase
        if (crtc[index_reg] == kept)
            return;
        crtc[index_reg] = kept;
        case (index_reg)
            tab_pkg::REG_MAX_SCAN: r.full_redraw_pulse = 1'b1;
            tab_pkg::REG_CURSOR_START, tab_pkg::REG_CURSOR_END:
                mark_cell(r, 1'b1, cursor_pos());
            tab_pkg::REG_START_HI, tab_pkg::REG_START_LO:
                if (prev_start != screen_start())
                    r.full_redraw_pulse = 1'b1;
            tab_pkg::REG_CURSOR_HI, tab_pkg::REG_CURSOR_LO:
            begin
                mark_cell(r, 1'b0, prev_cursor);
                mark_cell(r, 1'b1, cursor_pos());
            end
            default: ;
        endcase
    endfunction

    // apply one accepted access and queue its result
    function void note_access(tab_pkg::mode_t m, logic [19:0] a, logic [7:0] d,
                              logic [5:0] t);
        tab_pkg::result_t r;
        logic [3:0]       port;
        logic [13:0]      widx;
        logic [15:0]      word;
        logic [15:0]      nw;
        logic [7:0]       diff;
        r = '0;
        port = a[3:0];
        case (m)
            tab_pkg::MODE_IO_RD:
            begin
                if (port <= 4'd7 && port[0]) begin
                    r.claimed   = 1'b1;
                    r.read_data = (index_reg < tab_pkg::CRTC_LIMIT) ? crtc[index_reg] : 8'h00;
                end
                else if (port == tab_pkg::PORT_STATUS) begin
                    r.claimed   = 1'b1;
                    r.read_data = tab_pkg::STATUS_BASE | {4'b0000, t[3], 2'b00, t[5]};
                end
            end
            tab_pkg::MODE_IO_WR:
            begin
                r.claimed = 1'b1;
                if (port <= 4'd7) begin
                    if (port[0])
                        write_crtc(d, r);
                    else
                        index_reg = d[4:0];
                end
                else if (port == tab_pkg::PORT_MODE) begin
                    diff     = mode_ctl ^ d;
                    mode_ctl = d;
                    if (diff[tab_pkg::MC_HIRES_BIT])
                        r.full_redraw_pulse = 1'b1;
                    else if (diff[tab_pkg::MC_BLINK_BIT])
                        r.attr_high_pulse = 1'b1;
                end
            end
            default:
            begin
                if (a[19:15] == tab_pkg::WIN_TAG) begin
                    widx = a[14:1];
                    word = cells[widx];
                    r.claimed = 1'b1;
                    if (m == tab_pkg::MODE_MEM_RD) begin
                        r.read_data = a[0] ? word[15:8] : word[7:0];
                    end
                    else begin
                        nw = a[0] ? {d, word[7:0]} : {word[15:8], d};
                        if (nw != word) begin
                            cells[widx] = nw;
                            mark_cell(r, 1'b0, widx);
                        end
                    end
                end
            end
        endcase
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // compare one result transfer against the oldest expectation
    function void check_result(tab_pkg::result_t got);
        tab_pkg::result_t want;
        if (expected_q.size() == 0) begin
            $error("result transfer with no access outstanding");
            failures++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("claimed", want.claimed, got.claimed);
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("dirty_first_valid", want.dirty_first_valid, got.dirty_first_valid);
        compare_field("dirty_first_cell", want.dirty_first_cell, got.dirty_first_cell);
        compare_field("dirty_second_valid", want.dirty_second_valid, got.dirty_second_valid);
        compare_field("dirty_second_cell", want.dirty_second_cell, got.dirty_second_cell);
        compare_field("full_redraw_pulse", want.full_redraw_pulse, got.full_redraw_pulse);
        compare_field("attr_high_pulse", want.attr_high_pulse, got.attr_high_pulse);
    endfunction
endclass

module testbench;

    logic clk;
    logic rst_n;

    tab_req_if req_bus ();
    tab_rsp_if rsp_bus ();

    access_scoreboard sb;
    int sent_items;
    int burst_left;

    text_adapter_bus_interface #(
        .CELL_WORDS    (CELL_DEPTH),
        .VISIBLE_CELLS (SCREEN_CELLS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // io address with random upper bits
    function automatic logic [19:0] io_addr(input logic [3:0] port);
        return {16'($urandom), port};
    endfunction

    // offer one access, wait for its transfer, then maybe idle between bursts
    task automatic send_access(input tab_pkg::mode_t m, input logic [19:0] a,
                               input logic [7:0] d, input logic [5:0] t);
        int gap;
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= m;
        req_bus.address    <= a;
        req_bus.write_data <= d;
        req_bus.timer_bits <= t;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        sb.note_access(m, a, d, t);
        sent_items++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(1, 8);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 60);
        end
    endtask

    // index write then data write to one crtc register
    task automatic crtc_set(input logic [4:0] idx, input logic [7:0] d);
        send_access(tab_pkg::MODE_IO_WR, io_addr({1'b0, 2'($urandom), 1'b0}),
                    {3'($urandom), idx}, 6'($urandom));
        send_access(tab_pkg::MODE_IO_WR, io_addr({1'b0, 2'($urandom), 1'b1}), d,
                    6'($urandom));
    endtask

    // result monitor
    always @(posedge clk)
    begin
        tab_pkg::result_t got;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.claimed            = rsp_bus.claimed;
            got.read_data          = rsp_bus.read_data;
            got.dirty_first_valid  = rsp_bus.dirty_first_valid;
            got.dirty_first_cell   = rsp_bus.dirty_first_cell;
            got.dirty_second_valid = rsp_bus.dirty_second_valid;
            got.dirty_second_cell  = rsp_bus.dirty_second_cell;
            got.full_redraw_pulse  = rsp_bus.full_redraw_pulse;
            got.attr_high_pulse    = rsp_bus.attr_high_pulse;
            sb.check_result(got);
        end
    end

    // receiver: phased stall patterns plus one long hold-off
    initial
    begin : receiver
        int phase;
        int phase_left;
        int seen;
        int hold_left;
        int cyc;
        bit hold_done;
        phase      = 0;
        phase_left = 0;
        seen       = 0;
        hold_left  = 0;
        cyc        = 0;
        hold_done  = 1'b0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
                seen++;
            if (!hold_done && seen >= 300) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 4);
                phase_left = $urandom_range(32, 200);
            end
            else begin
                phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else begin
                case (phase)
                    0: rsp_bus.ready <= 1'b1;
                    1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                    3: rsp_bus.ready <= cyc[0];
                    default: rsp_bus.ready <= ((cyc % 8) < 5);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // reset, directed accesses, random accesses, drain
    initial
    begin : stimulus
        int          kind;
        int          rel;
        logic [13:0] cell_pos;
        logic        hb;
        logic [7:0]  d;
        logic [4:0]  idx;
        sb         = new();
        sent_items = 0;
        burst_left = 0;
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.mode       <= tab_pkg::MODE_IO_RD;
        req_bus.address    <= '0;
        req_bus.write_data <= '0;
        req_bus.timer_bits <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // status port at both timer extremes, unclaimed read, register 0 read
        send_access(tab_pkg::MODE_IO_RD, io_addr(tab_pkg::PORT_STATUS), 8'h00, 6'h3f);
        send_access(tab_pkg::MODE_IO_RD, io_addr(tab_pkg::PORT_STATUS), 8'hff, 6'h00);
        send_access(tab_pkg::MODE_IO_RD, io_addr(tab_pkg::PORT_MODE), 8'h00, 6'h15);
        send_access(tab_pkg::MODE_IO_RD, io_addr(4'h1), 8'h00, 6'h2a);
        // discarded port write
        send_access(tab_pkg::MODE_IO_WR, io_addr(4'h9), 8'hff, 6'h00);
        // masked registers, scan line redraw, cursor and start moves
        crtc_set(tab_pkg::REG_HSYNC_WIDTH, 8'hff);
        crtc_set(tab_pkg::REG_MAX_SCAN, 8'h0c);
        crtc_set(tab_pkg::REG_CURSOR_END, 8'hff);
        crtc_set(tab_pkg::REG_CURSOR_LO, 8'h10);
        crtc_set(tab_pkg::REG_START_LO, 8'h40);
        crtc_set(tab_pkg::REG_START_HI, 8'h00);
        // index past the file: write ignored, read gives zero
        crtc_set(5'd31, 8'h55);
        send_access(tab_pkg::MODE_IO_RD, io_addr(4'h3), 8'h00, 6'h3f);
        // mode control: hires change, then blink change
        send_access(tab_pkg::MODE_IO_WR, io_addr(tab_pkg::PORT_MODE), 8'h20, 6'h00);
        send_access(tab_pkg::MODE_IO_WR, io_addr(tab_pkg::PORT_MODE), 8'h00, 6'h00);
        // cell memory: write at screen start, unchanged write, window edges
        send_access(tab_pkg::MODE_MEM_WR, 20'hb0080, 8'h41, 6'h00);
        send_access(tab_pkg::MODE_MEM_WR, 20'hb0081, 8'h07, 6'h00);
        send_access(tab_pkg::MODE_MEM_RD, 20'hb7fff, 8'h00, 6'h00);
        send_access(tab_pkg::MODE_MEM_WR, 20'hb8000, 8'hff, 6'h00);
        send_access(tab_pkg::MODE_MEM_RD, 20'haffff, 8'h00, 6'h00);
        send_access(tab_pkg::MODE_IO_WR, 20'hfffff, 8'hff, 6'h3f);

        // random accesses, mostly screen traffic and crtc sequences
        while (sent_items < 1830) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                rel      = $urandom_range(0, 2199);
                cell_pos = sb.screen_start() + 14'(rel);
                hb       = 1'($urandom);
                d        = 8'($urandom);
                if ($urandom_range(0, 9) == 0)
                    d = hb ? sb.cells[cell_pos][15:8] : sb.cells[cell_pos][7:0];
                send_access(tab_pkg::MODE_MEM_WR, {tab_pkg::WIN_TAG, cell_pos, hb}, d,
                            6'($urandom));
            end
            else if (kind < 55) begin
                rel      = $urandom_range(0, 2199);
                cell_pos = sb.screen_start() + 14'(rel);
                send_access(tab_pkg::MODE_MEM_RD, {tab_pkg::WIN_TAG, cell_pos, 1'($urandom)},
                            8'($urandom), 6'($urandom));
            end
            else if (kind < 60) begin
                send_access(tab_pkg::mode_t'($urandom_range(2, 3)),
                            {tab_pkg::WIN_TAG, 15'($urandom)}, 8'($urandom), 6'($urandom));
            end
            else if (kind < 80) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: idx = 5'($urandom_range(0, tab_pkg::CRTC_COUNT - 1));
                    3: idx = 5'($urandom_range(tab_pkg::CRTC_COUNT, 31));
                    default: idx = 5'($urandom_range(tab_pkg::REG_MAX_SCAN,
                                                     tab_pkg::REG_CURSOR_LO));
                endcase
                d = 8'($urandom);
                if (idx == tab_pkg::REG_START_HI || idx == tab_pkg::REG_CURSOR_HI)
                    d = {2'($urandom), 3'b000, 3'($urandom)};
                if ($urandom_range(0, 3) == 0) begin
                    send_access(tab_pkg::MODE_IO_WR, io_addr({1'b0, 2'($urandom), 1'b0}),
                                {3'($urandom), idx}, 6'($urandom));
                    send_access(tab_pkg::MODE_IO_RD, io_addr({1'b0, 2'($urandom), 1'b1}), d,
                                6'($urandom));
                end
                else begin
                    crtc_set(idx, d);
                end
            end
            else if (kind < 88) begin
                case ($urandom_range(0, 4))
                    0: d = sb.mode_ctl ^ 8'h08;
                    1: d = sb.mode_ctl ^ 8'h20;
                    2: d = sb.mode_ctl ^ 8'h28;
                    3: d = sb.mode_ctl;
                    default: d = 8'($urandom);
                endcase
                send_access(tab_pkg::MODE_IO_WR, io_addr(tab_pkg::PORT_MODE), d,
                            6'($urandom));
            end
            else if (kind < 92) begin
                send_access(tab_pkg::MODE_IO_RD, io_addr(tab_pkg::PORT_STATUS), 8'($urandom),
                            6'($urandom));
            end
            else begin
                send_access(tab_pkg::mode_t'($urandom_range(0, 3)), 20'($urandom),
                            8'($urandom), 6'($urandom));
            end
        end
        req_bus.valid <= 1'b0;

        // drain outstanding results, then allow for pipeline latency
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
design/tab_pkg.sv
design/tab_if.sv
design/tab_cell_ram.sv
design/tab_exec.sv
design/text_adapter_bus_interface.sv
bench/testbench.sv
